### sv/rgb_convolution_3x3_core_assert.svh
// ----------------------------------------------------------------------------
// rgb convolution 3x3 assertion macros
// shared property forms for the filter's checks
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_CORE_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define RCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define RCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// types, constants and helpers of the rgb 3x3 convolution filter
// ----------------------------------------------------------------------------
package rcc_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT        = 4096;
   localparam int MIN_DIM           = 3;

   localparam int CH_W     = 8;
   localparam int NUM_CH   = 3;
   localparam int PIX_W    = CH_W * NUM_CH;
   localparam int TAPS     = 3;
   localparam int WIN_EDGE = TAPS - 1;
   localparam int COEF_W   = 16;
   localparam int KROW_W   = COEF_W * TAPS;

   localparam int WIDTH_CSR_W  = 11;
   localparam int HEIGHT_CSR_W = 13;
   localparam int ROW_W        = 12;
   localparam int CSR_DATA_W   = KROW_W;
   localparam int CSR_ADDR_W   = 3;

   localparam int PROD_W   = CH_W + 1 + COEF_W;
   localparam int ROWSUM_W = PROD_W + 2;
   localparam int SUM_W    = ROWSUM_W + 2;

   typedef logic [CH_W-1:0]   chan_type;
   typedef logic [KROW_W-1:0] krow_type;
   typedef krow_type [TAPS-1:0] kernel_type;

   // red in the lowest bits
   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } pix_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WIDTH    = 3'd0,
      CSR_HEIGHT   = 3'd1,
      CSR_K_TOP    = 3'd2,
      CSR_K_MIDDLE = 3'd3,
      CSR_K_BOTTOM = 3'd4
   } csr_index_type;

   localparam logic [WIDTH_CSR_W-1:0]  RST_WIDTH    = 11'd640;
   localparam logic [HEIGHT_CSR_W-1:0] RST_HEIGHT   = 13'd480;
   localparam krow_type                RST_K_TOP    = 48'h0000_FFFF_0000;
   localparam krow_type                RST_K_MIDDLE = 48'hFFFF_0005_FFFF;
   localparam krow_type                RST_K_BOTTOM = 48'h0000_FFFF_0000;

   // handoff from the line stage to the filter datapath
   typedef struct packed {
      logic go;
      logic emit;
      logic last;
   } step_type;

   function automatic logic signed [COEF_W-1:0] coeff(input krow_type row, input int pos);
      coeff = row[pos*COEF_W +: COEF_W];
   endfunction

   function automatic chan_type clamp_byte(input logic signed [SUM_W-1:0] v);
      if (v[SUM_W-1]) begin
         clamp_byte = '0;
      end else if (|v[SUM_W-2:CH_W]) begin
         clamp_byte = '1;
      end else begin
         clamp_byte = v[CH_W-1:0];
      end
   endfunction

endpackage

### sv/rcc_line_mem.sv
// ----------------------------------------------------------------------------
// rcc_line_mem
// two-row line store, one entry per column holding both previous rows
// ----------------------------------------------------------------------------
module rcc_line_mem #(
   parameter int MAX_WIDTH = rcc_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   output logic [2*rcc_pkg::PIX_W-1:0]    rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   input  logic [2*rcc_pkg::PIX_W-1:0]    wr_data
);

   `include "rgb_convolution_3x3_core_assert.svh"

   logic [2*rcc_pkg::PIX_W-1:0] mem_ff [MAX_WIDTH];
   logic [2*rcc_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // consecutive pixels always sit in different columns
   `RCC_ASSERT_SAME(a_rd_wr_apart, clock, reset, rd_en && wr_en, rd_addr != wr_addr, "line store read and write hit the same column")

endmodule

### sv/rcc_mac.sv
// ----------------------------------------------------------------------------
// rcc_mac
// 3x3 window, multiply, row sums, total with clamp and output register
// ----------------------------------------------------------------------------
module rcc_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  rcc_pkg::step_type              step,
   input  rcc_pkg::pix_type               pix,
   input  rcc_pkg::pix_type               col_top,
   input  rcc_pkg::pix_type               col_mid,
   input  rcc_pkg::kernel_type            kernel,
   output logic                           ready,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rcc_pkg::PIX_W-1:0]      rsp_tdata,   // red, green, blue
   output logic                           rsp_tlast
);

   `include "rgb_convolution_3x3_core_assert.svh"

   localparam int T  = rcc_pkg::TAPS;
   localparam int NC = rcc_pkg::NUM_CH;

   rcc_pkg::pix_type win_ff [T][T-1];
   rcc_pkg::pix_type cur [T];

   logic signed [rcc_pkg::PROD_W-1:0]   prod_in   [NC][T][T];
   logic signed [rcc_pkg::PROD_W-1:0]   prod_ff   [NC][T][T];
   logic signed [rcc_pkg::ROWSUM_W-1:0] rowsum_in [NC][T];
   logic signed [rcc_pkg::ROWSUM_W-1:0] rowsum_ff [NC][T];
   rcc_pkg::pix_type                    out_in;
   rcc_pkg::pix_type                    out_ff;

   logic s2_v_ff, s2_last_ff;
   logic s3_v_ff, s3_last_ff;
   logic out_v_ff, out_last_ff;
   logic s2_ready, s3_ready, out_ready;

   assign out_ready = !out_v_ff || rsp_tready;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign ready     = s2_ready;

   assign cur[0] = col_top;
   assign cur[1] = col_mid;
   assign cur[2] = pix;

   // window columns shift as each pixel leaves the line stage
   always_ff @(posedge clock) begin
      if (step.go) begin
         for (int r = 0; r < T; r++) begin
            for (int c = 0; c < T - 2; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][T-2] <= cur[r];
         end
      end
   end

   always_comb begin
      rcc_pkg::pix_type tap;
      tap = '0;
      for (int ch = 0; ch < NC; ch++) begin
         for (int r = 0; r < T; r++) begin
            for (int c = 0; c < T; c++) begin
               tap = (c < T - 1) ? win_ff[r][c] : cur[r];
               prod_in[ch][r][c] =
                  $signed({1'b0, tap[ch*rcc_pkg::CH_W +: rcc_pkg::CH_W]}) *
                  rcc_pkg::coeff(kernel[r], c);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         for (int r = 0; r < T; r++) begin
            rowsum_in[ch][r] = rcc_pkg::ROWSUM_W'(prod_ff[ch][r][0]) +
                               rcc_pkg::ROWSUM_W'(prod_ff[ch][r][1]) +
                               rcc_pkg::ROWSUM_W'(prod_ff[ch][r][2]);
         end
      end
   end

   always_comb begin
      logic signed [rcc_pkg::SUM_W-1:0] total;
      out_in = '0;
      total  = '0;
      for (int ch = 0; ch < NC; ch++) begin
         total = rcc_pkg::SUM_W'(rowsum_ff[ch][0]) +
                 rcc_pkg::SUM_W'(rowsum_ff[ch][1]) +
                 rcc_pkg::SUM_W'(rowsum_ff[ch][2]);
         out_in[ch*rcc_pkg::CH_W +: rcc_pkg::CH_W] = rcc_pkg::clamp_byte(total);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_v_ff <= step.go && step.emit;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_ready) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         prod_ff    <= prod_in;
         s2_last_ff <= step.last;
      end
      if (s3_ready) begin
         rowsum_ff  <= rowsum_in;
         s3_last_ff <= s2_last_ff;
      end
      if (out_ready) begin
         out_ff      <= out_in;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;

   // the pipe only backs up from a stalled output word
   `RCC_ASSERT_SAME(a_stall_from_output, clock, reset, !s2_ready, out_v_ff && !rsp_tready, "filter pipe stalled without a waiting output word")

endmodule

### sv/rgb_convolution_3x3_core.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_core
// streaming 3x3 convolution filter for rgb pixels in raster order
// ----------------------------------------------------------------------------
// req_ takes one pixel word per clock unless stalled, raster order, red in low byte.
// rsp_ gives one filtered word per interior pixel (row and column both at
// least 2); the output frame is (width-2) by (height-2) and tlast marks its
// final word. Each channel is the signed 3x3 kernel sum clamped to 0..255.
// csr_ writes image width, image height and the three kernel rows (three
// signed 16-bit taps each, left tap in the low bits); write only when idle.
// Throughput is one pixel per clock unless the output stalls, set by the line
// store: one read and one write of the same memory per pixel, in different columns.
// A result word passes the line stage, product, row-sum and output registers.
// Reset clears counters and pipe valids and loads the sharpen kernel,
// width 640 and height 480; the line store holds no reset value and takes
// no clearing pass, so the first two rows are filled before any use.
// When the receiver stalls, the result holds and the pipe keeps taking
// pixels until its bubbles are used up, then req_tready drops.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_core #(
   parameter int MAX_WIDTH = rcc_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rcc_pkg::PIX_W-1:0]          req_tdata,   // in_red, in_green, in_blue
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rcc_pkg::PIX_W-1:0]          rsp_tdata,   // out_red, out_green, out_blue
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [rcc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rcc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   `include "rgb_convolution_3x3_core_assert.svh"

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = ($clog2(MAX_WIDTH + 1) > rcc_pkg::WIDTH_CSR_W) ?
                          $clog2(MAX_WIDTH + 1) : rcc_pkg::WIDTH_CSR_W;
   localparam int HW    = rcc_pkg::HEIGHT_CSR_W;
   localparam int PW    = rcc_pkg::PIX_W;

   logic [rcc_pkg::WIDTH_CSR_W-1:0] width_ff;
   logic [HW-1:0]                   height_ff;
   rcc_pkg::kernel_type             kernel_ff;

   logic [COL_W-1:0]          col_ff, col_in;
   logic [rcc_pkg::ROW_W-1:0] row_ff, row_in;

   logic [WW-1:0] w_raw, w_eff;
   logic [HW-1:0] h_eff;
   logic          end_row, end_frame, emit, accept;

   logic             s1_v_ff, s1_emit_ff, s1_last_ff;
   rcc_pkg::pix_type s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_go, mac_ready;

   logic [2*PW-1:0]   rd_data, wr_data;
   rcc_pkg::step_type step;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rcc_pkg::RST_WIDTH;
         height_ff    <= rcc_pkg::RST_HEIGHT;
         kernel_ff[0] <= rcc_pkg::RST_K_TOP;
         kernel_ff[1] <= rcc_pkg::RST_K_MIDDLE;
         kernel_ff[2] <= rcc_pkg::RST_K_BOTTOM;
      end else if (csr_wr_en) begin
         unique case (rcc_pkg::csr_index_type'(csr_addr))
            rcc_pkg::CSR_WIDTH:    width_ff     <= csr_wdata[rcc_pkg::WIDTH_CSR_W-1:0];
            rcc_pkg::CSR_HEIGHT:   height_ff    <= csr_wdata[HW-1:0];
            rcc_pkg::CSR_K_TOP:    kernel_ff[0] <= csr_wdata;
            rcc_pkg::CSR_K_MIDDLE: kernel_ff[1] <= csr_wdata;
            rcc_pkg::CSR_K_BOTTOM: kernel_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective frame size
   assign w_raw = WW'(width_ff);
   assign w_eff = (w_raw < WW'(rcc_pkg::MIN_DIM)) ? WW'(rcc_pkg::MIN_DIM) :
                  (w_raw > WW'(MAX_WIDTH))        ? WW'(MAX_WIDTH) : w_raw;
   assign h_eff = (height_ff < HW'(rcc_pkg::MIN_DIM))  ? HW'(rcc_pkg::MIN_DIM) :
                  (height_ff > HW'(rcc_pkg::MAX_HEIGHT)) ? HW'(rcc_pkg::MAX_HEIGHT) :
                  height_ff;

   // position of the incoming pixel
   assign end_row   = (WW'(col_ff) + WW'(1)) >= w_eff;
   assign end_frame = end_row && ((HW'(row_ff) + HW'(1)) >= h_eff);
   assign emit      = (row_ff >= rcc_pkg::ROW_W'(rcc_pkg::WIN_EDGE)) &&
                      (col_ff >= COL_W'(rcc_pkg::WIN_EDGE));

   assign col_in = end_row ? '0 : col_ff + COL_W'(1);
   assign row_in = end_frame ? '0 : (end_row ? row_ff + rcc_pkg::ROW_W'(1) : row_ff);

   // line stage handshake
   assign s1_go      = s1_v_ff && (!s1_emit_ff || mac_ready);
   assign req_tready = !s1_v_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         s1_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (req_tready) begin
            s1_v_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= rcc_pkg::pix_type'(req_tdata);
         s1_col_ff  <= col_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= end_frame;
      end
   end

   // top row moves out, middle row moves up, new pixel becomes middle
   assign wr_data = {PW'(s1_pix_ff), rd_data[2*PW-1:PW]};

   rcc_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   assign step.go   = s1_go;
   assign step.emit = s1_emit_ff;
   assign step.last = s1_last_ff;

   rcc_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .pix        (s1_pix_ff),
      .col_top    (rcc_pkg::pix_type'(rd_data[PW-1:0])),
      .col_mid    (rcc_pkg::pix_type'(rd_data[2*PW-1:PW])),
      .kernel     (kernel_ff),
      .ready      (mac_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `RCC_ASSERT_NEXT(a_frame_wrap, clock, reset, accept && end_frame,
                    col_ff == '0 && row_ff == '0,
                    "position not cleared after the last pixel of a frame")

endmodule

### bench/tb_rgb_convolution_3x3_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_convolution_3x3_core
// self-checking bench for the streaming rgb 3x3 convolution filter
// ----------------------------------------------------------------------------
// Pixel words go in as raster-ordered frames with random idle gaps on the
// request side and random stalls on the result side. A window checker keeps
// its own line buffers, window history and row/column position, works out
// each filtered word as pixels are accepted, and compares every result word
// in order. Frames run from the smallest size through random small sizes
// and kernels, with size changes in the middle of a frame, including size
// values below the minimum.
// ----------------------------------------------------------------------------
module tb_rgb_convolution_3x3_core;
   import rcc_pkg::*;

   localparam int          RESULT_LATENCY = 4;
   localparam int          SETTLE_CYCLES  = RESULT_LATENCY + 4;
   localparam int          RANDOM_ITEMS   = 420;
   localparam int unsigned CYCLE_LIMIT    = 4_000_000;
   localparam int          MAX_REPORTS    = 10;

   typedef struct packed {
      pix_type pix;
      logic    last;
   } filt_word_type;

   class conv_window_checker;
      logic [WIDTH_CSR_W-1:0]  width_reg;
      logic [HEIGHT_CSR_W-1:0] height_reg;
      krow_type                krow [TAPS];
      pix_type                 line_buf [2][DEFAULT_MAX_WIDTH];
      pix_type                 hist [TAPS][2];
      int unsigned             col, row;
      filt_word_type           pending_words [$];
      int unsigned             pixels, words, errors;

      function new();
         width_reg  = RST_WIDTH;
         height_reg = RST_HEIGHT;
         krow[0]    = RST_K_TOP;
         krow[1]    = RST_K_MIDDLE;
         krow[2]    = RST_K_BOTTOM;
         for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < DEFAULT_MAX_WIDTH; c++) begin
               line_buf[r][c] = '0;
            end
         end
         for (int r = 0; r < TAPS; r++) begin
            hist[r][0] = '0;
            hist[r][1] = '0;
         end
         col    = 0;
         row    = 0;
         pixels = 0;
         words  = 0;
         errors = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("%s", msg);
         end
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, krow_type data);
         case (addr)
            CSR_WIDTH:    width_reg  = data[WIDTH_CSR_W-1:0];
            CSR_HEIGHT:   height_reg = data[HEIGHT_CSR_W-1:0];
            CSR_K_TOP:    krow[0]    = data;
            CSR_K_MIDDLE: krow[1]    = data;
            CSR_K_BOTTOM: krow[2]    = data;
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (width_reg < MIN_DIM) return MIN_DIM;
         if (width_reg > DEFAULT_MAX_WIDTH) return DEFAULT_MAX_WIDTH;
         return int'(width_reg);
      endfunction

      function int unsigned eff_height();
         if (height_reg < MIN_DIM) return MIN_DIM;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return int'(height_reg);
      endfunction

      function bit frame_start();
         return col == 0 && row == 0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void note_pixel(pix_type px);
         pix_type                  taps [TAPS][TAPS];
         int unsigned              w_eff, h_eff;
         bit                       end_row, end_frame;
         int                       acc;
         logic signed [COEF_W-1:0] k;
         logic [CH_W-1:0]          chan;
         filt_word_type            wd;
         w_eff     = eff_width();
         h_eff     = eff_height();
         end_row   = (col + 1 >= w_eff);
         end_frame = end_row && (row + 1 >= h_eff);
         for (int r = 0; r < TAPS; r++) begin
            taps[r][0] = hist[r][0];
            taps[r][1] = hist[r][1];
         end
         taps[0][2] = line_buf[0][col];
         taps[1][2] = line_buf[1][col];
         taps[2][2] = px;
         if (row >= 2 && col >= 2) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               acc = 0;
               for (int r = 0; r < TAPS; r++) begin
                  for (int c = 0; c < TAPS; c++) begin
                     k    = krow[r][c*COEF_W +: COEF_W];
                     chan = taps[r][c][ch*CH_W +: CH_W];
                     acc += int'(chan) * int'(k);
                  end
               end
               if (acc < 0) begin
                  wd.pix[ch*CH_W +: CH_W] = '0;
               end else if (acc > 255) begin
                  wd.pix[ch*CH_W +: CH_W] = '1;
               end else begin
                  wd.pix[ch*CH_W +: CH_W] = acc[CH_W-1:0];
               end
            end
            wd.last = end_frame;
            pending_words = {pending_words, wd};
         end
         for (int r = 0; r < TAPS; r++) begin
            hist[r][0] = taps[r][1];
            hist[r][1] = taps[r][2];
         end
         line_buf[0][col] = taps[1][2];
         line_buf[1][col] = px;
         if (end_row) begin
            col = 0;
            row = end_frame ? 0 : row + 1;
         end else begin
            col++;
         end
         pixels++;
      endfunction

      function void check_word(logic [PIX_W-1:0] data, logic last);
         pix_type       got;
         filt_word_type exp_w;
         got = data;
         words++;
         if (pending_words.size() == 0) begin
            flag($sformatf("unexpected word r=%0d g=%0d b=%0d last=%0b",
                           got.red, got.green, got.blue, last));
            return;
         end
         exp_w = pending_words.pop_front();
         if (got.red !== exp_w.pix.red || got.green !== exp_w.pix.green ||
             got.blue !== exp_w.pix.blue || last !== exp_w.last) begin
            flag($sformatf({"word %0d: expected r=%0d g=%0d b=%0d last=%0b, ",
                            "got r=%0d g=%0d b=%0d last=%0b"},
                           words, exp_w.pix.red, exp_w.pix.green, exp_w.pix.blue,
                           exp_w.last, got.red, got.green, got.blue, last));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIX_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   conv_window_checker sb;
   bit                 steady;
   int unsigned        cycle_count = 0;
   int                 frames;

   rgb_convolution_3x3_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(rsp_tdata, rsp_tlast);
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic pix_type mk_pix(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                      logic [CH_W-1:0] b);
      pix_type p;
      p.red   = r;
      p.green = g;
      p.blue  = b;
      return p;
   endfunction

   function automatic logic [CH_W-1:0] rand_chan();
      if ($urandom_range(0, 4) == 0) begin
         return ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      return CH_W'($urandom_range(0, 255));
   endfunction

   function automatic pix_type rand_pixel();
      return mk_pix(rand_chan(), rand_chan(), rand_chan());
   endfunction

   function automatic krow_type rand_krow();
      krow_type v;
      int       mode;
      mode = $urandom_range(0, 8);
      for (int t = 0; t < TAPS; t++) begin
         if (mode < 5) begin
            v[t*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 12)) - 5);
         end else if (mode < 8) begin
            v[t*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 16'hFFFF));
         end else begin
            case ($urandom_range(0, 4))
               0:       v[t*COEF_W +: COEF_W] = 16'h8000;
               1:       v[t*COEF_W +: COEF_W] = 16'h7FFF;
               2:       v[t*COEF_W +: COEF_W] = 16'hFFFF;
               3:       v[t*COEF_W +: COEF_W] = 16'h0001;
               default: v[t*COEF_W +: COEF_W] = 16'h0000;
            endcase
         end
      end
      return v;
   endfunction

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(addr, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input pix_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(px);
   endtask

   // hold the sender until every filtered word is out and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_frame(input int cut_at);
      int n;
      n = 0;
      do begin
         send_pixel(rand_pixel());
         n++;
         if (n == cut_at && !sb.frame_start()) begin
            // size change in the middle of a frame, width never grows
            settle();
            if ($urandom_range(0, 1) == 1) begin
               csr_write(CSR_HEIGHT, CSR_DATA_W'($urandom_range(0, 8)));
            end else begin
               csr_write(CSR_WIDTH, CSR_DATA_W'($urandom_range(0, sb.eff_width())));
            end
         end
      end while (!sb.frame_start());
      frames++;
   endtask

   initial begin
      int      roll, cut, base;
      bit      first_frame;
      pix_type corner, side_px, center;
      sb     = new();
      frames = 0;
      steady = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wr_en  <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame on the reset sharpen kernel: red clamps high,
      // green clamps low, blue stays in range
      csr_write(CSR_WIDTH, CSR_DATA_W'(3));
      csr_write(CSR_HEIGHT, CSR_DATA_W'(3));
      corner  = mk_pix(8'hFF, 8'hFF, 8'hFF);
      side_px = mk_pix(8'd0, 8'd255, 8'd10);
      center  = mk_pix(8'd255, 8'd0, 8'd30);
      for (int i = 0; i < 9; i++) begin
         send_pixel(i == 4 ? center : ((i % 2 == 1) ? side_px : corner));
      end
      frames++;
      settle();

      // sizes below the minimum, extreme taps, writes past the register list
      csr_write(CSR_WIDTH, CSR_DATA_W'(0));
      csr_write(CSR_HEIGHT, CSR_DATA_W'(2));
      csr_write(CSR_K_TOP, 48'h7FFF_7FFF_7FFF);
      csr_write(CSR_K_MIDDLE, 48'h8000_8000_8000);
      csr_write(CSR_K_BOTTOM, 48'h0001_0000_FFFF);
      for (int a = int'(CSR_K_BOTTOM) + 1; a < (1 << CSR_ADDR_W); a++) begin
         csr_write(CSR_ADDR_W'(a), '1);
      end
      for (int i = 0; i < 9; i++) begin
         send_pixel(mk_pix((i % 2 == 1) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
                           (i > 4) ? 8'hFF : 8'h00));
      end
      frames++;
      settle();

      // random small frames and kernels
      base        = sb.pixels;
      first_frame = 1'b1;
      while (sb.pixels - base < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         roll   = $urandom_range(0, 99);
         if (roll < 85) begin
            csr_write(CSR_WIDTH, CSR_DATA_W'($urandom_range(3, 8)));
         end else if (roll < 90) begin
            csr_write(CSR_WIDTH, CSR_DATA_W'($urandom_range(0, 2)));
         end else begin
            csr_write(CSR_WIDTH, CSR_DATA_W'($urandom_range(9, 24)));
         end
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            csr_write(CSR_HEIGHT, CSR_DATA_W'($urandom_range(3, 5)));
         end else if (roll < 95) begin
            csr_write(CSR_HEIGHT, CSR_DATA_W'($urandom_range(0, 2)));
         end else begin
            csr_write(CSR_HEIGHT, CSR_DATA_W'($urandom_range(6, 8)));
         end
         if ($urandom_range(0, 9) < 7) csr_write(CSR_K_TOP, rand_krow());
         if ($urandom_range(0, 9) < 7) csr_write(CSR_K_MIDDLE, rand_krow());
         if ($urandom_range(0, 9) < 7) csr_write(CSR_K_BOTTOM, rand_krow());
         if ($urandom_range(0, 9) == 0) begin
            csr_write(CSR_ADDR_W'($urandom_range(int'(CSR_K_BOTTOM) + 1,
                                                 (1 << CSR_ADDR_W) - 1)),
                      {rand_krow()});
         end
         cut = 0;
         if (first_frame || $urandom_range(0, 2) == 0) begin
            cut = $urandom_range(1, sb.eff_width() * sb.eff_height() - 1);
         end
         first_frame = 1'b0;
         run_frame(cut);
         settle();
      end
      steady = 1'b0;

      if (sb.pending() != 0) begin
         sb.flag($sformatf("%0d filtered words never arrived", sb.pending()));
      end
      $display("ran %0d frames, %0d pixel words in, %0d filtered words checked",
               frames, sb.pixels, sb.words);
      $display("frames from 3x3 up to 24 wide and 8 tall, random kernels, mid-frame resizes");
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int n;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

endmodule
